// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form on the block clock and reset.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

// File: sv/aid_pkg.sv
// Package for the ARM instruction decoder: classes, shift codes, patterns, result type.
`timescale 1ns / 1ps

package aid_pkg;

  typedef enum logic [4:0] {
    CLS_BX   = 5'd0,
    CLS_DP   = 5'd1,
    CLS_MRS  = 5'd2,
    CLS_MSRR = 5'd3,
    CLS_MSRF = 5'd4,
    CLS_MUL  = 5'd5,
    CLS_MULL = 5'd6,
    CLS_SWP  = 5'd7,
    CLS_HWR  = 5'd8,
    CLS_HWI  = 5'd9,
    CLS_SDT  = 5'd10,
    CLS_BDT  = 5'd11,
    CLS_B    = 5'd12,
    CLS_SWI  = 5'd13,
    CLS_CDT  = 5'd14,
    CLS_CDO  = 5'd15,
    CLS_CRT  = 5'd16,
    CLS_UND  = 5'd17,
    CLS_INV  = 5'd18
  } aid_class_e;

  localparam logic [3:0] SHM_NONE    = 4'd0;
  localparam logic [3:0] SHM_LSL_IMM = 4'd1;
  localparam logic [3:0] SHM_RRX     = 4'd5;
  localparam logic [3:0] SHM_LSL_REG = 4'd6;

  localparam logic [1:0] SHT_LSL = 2'd0;
  localparam logic [1:0] SHT_ROR = 2'd3;

  localparam logic [1:0] MOP_MUL  = 2'd0;
  localparam logic [1:0] MOP_MULL = 2'd1;
  localparam logic [1:0] MOP_SWP  = 2'd2;

  localparam logic [31:0] MASK_BX    = 32'h0FFF_FFF0;
  localparam logic [31:0] MATCH_BX   = 32'h012F_FF10;
  localparam logic [31:0] MASK_MRS   = 32'h0FBF_0FFF;
  localparam logic [31:0] MATCH_MRS  = 32'h010F_0000;
  localparam logic [31:0] MASK_MSRR  = 32'h0FBF_FFF0;
  localparam logic [31:0] MATCH_MSRR = 32'h0129_F000;
  localparam logic [31:0] MASK_MSRF  = 32'h0DBF_F000;
  localparam logic [31:0] MATCH_MSRF = 32'h0128_F000;

  typedef struct packed {
    aid_class_e  cls;
    logic [3:0]  cond;
    logic [3:0]  alu;
    logic [5:0]  flags;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [3:0]  rc;
    logic [3:0]  rd;
    logic [3:0]  smode;
    logic [5:0]  samt;
    logic [31:0] val;
    logic        imm;
  } aid_result_t;

endpackage

// File: sv/aid_decode.sv
// Combinational decode of one ARM-state instruction word into class and fields.
`timescale 1ns / 1ps

module aid_decode import aid_pkg::*; (
  input  logic [31:0] pc_i,
  input  logic [31:0] word_i,
  output aid_result_t res_o
);

  // 8-bit immediate rotated right by twice bits 11..8.
  function automatic logic [31:0] rot_imm(input logic [31:0] w);
    logic [63:0] dbl;
    logic [4:0]  r;
    dbl = {24'b0, w[7:0], 24'b0, w[7:0]};
    r   = {w[11:8], 1'b0};
    return dbl[31:0] >> r | dbl[63:32] << (6'd32 - {1'b0, r});
  endfunction

  // Register operand with shift, bits 11..0.
  function automatic aid_result_t shreg(input aid_result_t b, input logic [31:0] w);
    aid_result_t o;
    o    = b;
    o.rd = w[3:0];
    if (w[4]) begin
      o.smode = SHM_LSL_REG + {2'b0, w[6:5]};
      o.rc    = w[11:8];
    end else if (w[11:7] == 5'd0 && w[6:5] == SHT_LSL) begin
      o.smode = SHM_NONE;
    end else if (w[11:7] == 5'd0 && w[6:5] == SHT_ROR) begin
      o.smode = SHM_RRX;
    end else begin
      o.smode = SHM_LSL_IMM + {2'b0, w[6:5]};
      o.samt  = (w[11:7] == 5'd0) ? 6'd32 : {1'b0, w[11:7]};
    end
    return o;
  endfunction

  // Data processing and PSR transfers.
  function automatic aid_result_t dp_psr(input aid_result_t b, input logic [31:0] w);
    aid_result_t o;
    o = b;
    if ((w & MASK_MRS) == MATCH_MRS) begin
      o.ra  = w[15:12];
      o.cls = CLS_MRS;
    end else if ((w & MASK_MSRR) == MATCH_MSRR) begin
      o.rd  = w[3:0];
      o.cls = CLS_MSRR;
    end else if ((w & MASK_MSRF) == MATCH_MSRF) begin
      if (w[25]) begin
        o.val = rot_imm(w);
        o.imm = 1'b1;
      end else begin
        o.rd = w[3:0];
      end
      o.cls = CLS_MSRF;
    end else begin
      o.alu = w[24:21];
      o.rb  = w[19:16];
      o.ra  = w[15:12];
      if (w[25]) begin
        o.val = rot_imm(w);
        o.imm = 1'b1;
      end else begin
        o = shreg(o, w);
      end
      o.cls = CLS_DP;
    end
    return o;
  endfunction

  aid_result_t base;
  logic [31:0] br_off;

  assign br_off = {{6{word_i[23]}}, word_i[23:0], 2'b00};

  always_comb begin
    base       = '0;
    base.cls   = CLS_INV;
    base.cond  = word_i[31:28];
    base.flags = word_i[25:20];
    res_o      = base;
    if ((word_i & MASK_BX) == MATCH_BX) begin
      res_o.rd  = word_i[3:0];
      res_o.cls = CLS_BX;
    end else begin
      unique case (word_i[27:25])
        3'd0: begin
          if (word_i[7:4] == 4'h9) begin
            unique case (word_i[24:23])
              MOP_MUL: begin
                res_o.rc  = word_i[11:8];
                res_o.rd  = word_i[3:0];
                res_o.ra  = word_i[19:16];
                res_o.rb  = word_i[15:12];
                res_o.cls = CLS_MUL;
              end
              MOP_MULL: begin
                res_o.rc  = word_i[11:8];
                res_o.rd  = word_i[3:0];
                res_o.ra  = word_i[15:12];
                res_o.rb  = word_i[19:16];
                res_o.cls = CLS_MULL;
              end
              MOP_SWP: begin
                res_o.rd  = word_i[3:0];
                res_o.ra  = word_i[15:12];
                res_o.rb  = word_i[19:16];
                res_o.cls = CLS_SWP;
              end
              default: res_o.cls = CLS_INV;
            endcase
          end else if (word_i[7] && word_i[4]) begin
            // signed halfword store does not exist
            if (!word_i[20] && word_i[6]) begin
              res_o.cls = CLS_INV;
            end else begin
              res_o.alu = {2'b00, word_i[6:5]};
              res_o.ra  = word_i[15:12];
              res_o.rb  = word_i[19:16];
              if (word_i[22]) begin
                res_o.val = {24'b0, word_i[11:8], word_i[3:0]};
                res_o.imm = 1'b1;
                res_o.cls = CLS_HWI;
              end else begin
                res_o.rd  = word_i[3:0];
                res_o.cls = CLS_HWR;
              end
            end
          end else begin
            res_o = dp_psr(base, word_i);
          end
        end
        3'd1: res_o = dp_psr(base, word_i);
        3'd2, 3'd3: begin
          if (word_i[25] && word_i[4]) begin
            res_o.cls = CLS_UND;
          end else begin
            res_o.ra = word_i[15:12];
            res_o.rb = word_i[19:16];
            if (word_i[25]) begin
              res_o = shreg(res_o, word_i);
            end else begin
              res_o.val = {20'b0, word_i[11:0]};
              res_o.imm = 1'b1;
            end
            res_o.cls = CLS_SDT;
          end
        end
        3'd4: begin
          res_o.rb  = word_i[19:16];
          res_o.val = {16'b0, word_i[15:0]};
          res_o.cls = CLS_BDT;
        end
        3'd5: begin
          res_o.val = pc_i + 32'd8 + br_off;
          res_o.cls = CLS_B;
        end
        3'd6: res_o.cls = CLS_CDT;
        default: begin
          if (word_i[24]) begin
            res_o.val = {8'b0, word_i[23:0]};
            res_o.imm = 1'b1;
            res_o.cls = CLS_SWI;
          end else if (word_i[4]) begin
            res_o.cls = CLS_CRT;
          end else begin
            res_o.cls = CLS_CDO;
          end
        end
      endcase
    end
  end

endmodule

// File: sv/arm_instruction_decoder.sv
// ARM-state instruction decoder: top level with input and result registers.
// Takes one instruction word and its fetch address per request and returns
// one decoded result per request, in order. Two register stages: the input
// register captures the request, a single pass of decode logic (pattern
// matches, immediate rotator, address plus 8 plus offset for the branch
// target) feeds the result register. Throughput is one request per cycle
// while out_ready_i does not stall it. Both stages advance independently,
// so a new request is taken while a finished result still waits for
// out_ready_i, as long as the input stage is empty. Fields not used by a
// class read as zero. No configuration, no state beyond the registers.
`timescale 1ns / 1ps

module arm_instruction_decoder import aid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] fetch_address_i,
  input  logic [31:0] instruction_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  instr_class_o,
  output logic [3:0]  cond_code_o,
  output logic [3:0]  alu_opcode_o,
  output logic [5:0]  control_flags_o,
  output logic [3:0]  reg_a_o,
  output logic [3:0]  reg_b_o,
  output logic [3:0]  reg_c_o,
  output logic [3:0]  reg_d_o,
  output logic [3:0]  shift_mode_o,
  output logic [5:0]  shift_distance_o,
  output logic [31:0] operand_value_o,
  output logic        operand_is_immediate_o
);

  // input stage
  logic        in_valid_q, in_valid_d;
  logic [31:0] pc_q, word_q;
  // result stage
  logic        out_valid_q, out_valid_d;
  aid_result_t res_q, res_d;
  logic        res_ready;

  // result register frees when empty or being drained
  assign res_ready  = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || res_ready;

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = res_ready ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pc_q   <= fetch_address_i;
      word_q <= instruction_word_i;
    end
    if (in_valid_q && res_ready) begin
      res_q <= res_d;
    end
  end

  aid_decode u_decode (
    .pc_i   (pc_q),
    .word_i (word_q),
    .res_o  (res_d)
  );

  assign out_valid_o            = out_valid_q;
  assign instr_class_o          = res_q.cls;
  assign cond_code_o            = res_q.cond;
  assign alu_opcode_o           = res_q.alu;
  assign control_flags_o        = res_q.flags;
  assign reg_a_o                = res_q.ra;
  assign reg_b_o                = res_q.rb;
  assign reg_c_o                = res_q.rc;
  assign reg_d_o                = res_q.rd;
  assign shift_mode_o           = res_q.smode;
  assign shift_distance_o       = res_q.samt;
  assign operand_value_o        = res_q.val;
  assign operand_is_immediate_o = res_q.imm;

endmodule

// File: sv/aid_checker.sv
// Port-level assertions for the ARM instruction decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aid_checker import aid_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] fetch_address_i,
  input logic [31:0] instruction_word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  instr_class_o,
  input logic [3:0]  cond_code_o,
  input logic [3:0]  alu_opcode_o,
  input logic [5:0]  control_flags_o,
  input logic [3:0]  reg_a_o,
  input logic [3:0]  reg_b_o,
  input logic [3:0]  reg_c_o,
  input logic [3:0]  reg_d_o,
  input logic [3:0]  shift_mode_o,
  input logic [5:0]  shift_distance_o,
  input logic [31:0] operand_value_o,
  input logic        operand_is_immediate_o
);

  `ASSERT_DEF(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(instr_class_o) && $stable(operand_value_o), "result changed while stalled")
  `ASSERT_DEF(a_class_range, out_valid_o |-> instr_class_o <= CLS_INV, "class code out of range")
  `ASSERT_DEF(a_bare_class, out_valid_o && instr_class_o >= CLS_CDT |-> reg_a_o == 4'd0 && reg_b_o == 4'd0 && reg_c_o == 4'd0 && reg_d_o == 4'd0 && alu_opcode_o == 4'd0 && shift_mode_o == SHM_NONE && operand_value_o == 32'd0 && !operand_is_immediate_o, "fields set on bare class")
  `ASSERT_DEF(a_shift_amt, out_valid_o && (shift_mode_o == SHM_NONE || shift_mode_o == SHM_RRX || shift_mode_o >= SHM_LSL_REG) |-> shift_distance_o == 6'd0, "shift amount without immediate shift")

endmodule

bind arm_instruction_decoder aid_checker u_aid_checker (.*);
